[design/hdrdf_pkg.sv]
// Shared types, constants and helpers for the header deframer.
package hdrdf_pkg;

  localparam int HEADER_BYTES = 32;
  localparam int IDX_W        = $clog2(HEADER_BYTES);
  localparam int MAGIC_BYTES  = 4;
  localparam int REST_START   = MAGIC_BYTES;

  localparam logic [7:0]  MAX_VERSION_RST   = 8'd1;
  localparam logic [23:0] RESYNC_BUDGET_RST = 24'd4096;

  typedef enum logic [0:0] {
    REG_MAX_VERSION   = 1'b0,
    REG_RESYNC_BUDGET = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RESYNC = 2'd1,
    ST_ERROR  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_COLLECT = 3'b001,
    PH_SCAN    = 3'b010,
    PH_REST    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  version;
    logic [7:0]  flags;
    logic [7:0]  msg_type;
    logic [7:0]  model_code;
    logic [31:0] seq;
    logic [63:0] timestamp;
    logic [31:0] source_length;
    logic [31:0] body_length;
    logic [31:0] body_check;
    logic [31:0] bad_frame_total;
  } hdr_res_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] m;
    case (pos)
      2'd0:    m = 8'h4E;
      2'd1:    m = 8'h50;
      2'd2:    m = 8'h53;
      2'd3:    m = 8'h54;
      default: m = 8'h4E;
    endcase
    return m;
  endfunction

endpackage

[design/header_deframer_magic_resync.sv]
// Top level of the header deframer with magic-word resync.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | byte_req
//  rsp     | out       | rsp_valid/rsp_stall  | status .. bad_frame_total
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// One byte per cycle while req_stall is low. A result is registered into the
// output register, or into the skid entry while the output is stalled. The
// 32-cell byte shift line advances on every accepted byte. Reset needs no
// clearing pass. An output register plus one skid entry absorb rsp stalls;
// req_stall rises only while the skid entry is occupied.
module header_deframer_magic_resync import hdrdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [7:0]  byte_req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [7:0]  version,
  output logic [7:0]  flags,
  output logic [7:0]  msg_type,
  output logic [7:0]  model_code,
  output logic [31:0] seq,
  output logic [63:0] timestamp,
  output logic [31:0] source_length,
  output logic [31:0] body_length,
  output logic [31:0] body_check,
  output logic [31:0] bad_frame_total,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [7:0]       cell_q [HEADER_BYTES];
  logic [7:0]       hn     [HEADER_BYTES];
  logic             accept;

  logic [7:0]       max_version;
  logic [23:0]      resync_budget;

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [2:0]       magic_progress, magic_progress_next;
  logic [23:0]      budget_left, budget_left_next;
  logic [31:0]      bad_frames_seen, bad_frames_seen_next;

  logic             emit;
  hdr_res_t         res_new;
  hdr_res_t         out_q, skid_q;
  logic             skid_valid;

  logic [23:0]      bl_dec;
  logic [2:0]       prog_inc;
  logic             hdr_ok;
  logic             take;

  assign accept    = req_valid && !req_stall;
  assign req_stall = skid_valid;
  assign take      = rsp_valid && !rsp_stall;

  genvar gi;
  generate
    for (gi = 0; gi < HEADER_BYTES; gi++) begin : g_cell
      if (gi == HEADER_BYTES - 1) begin : g_tail
        assign hn[gi] = byte_req;
      end else begin : g_body
        assign hn[gi] = cell_q[gi+1];
      end
      hdrdf_cell u_cell (
        .clk  (clk),
        .shift(accept),
        .din  (hn[gi]),
        .dout (cell_q[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      max_version   <= MAX_VERSION_RST;
      resync_budget <= RESYNC_BUDGET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_VERSION:   max_version   <= cfg_data[7:0];
        REG_RESYNC_BUDGET: resync_budget <= cfg_data;
        default: ;
      endcase
    end
  end

  assign bl_dec   = (budget_left != '0) ? budget_left - 24'd1 : budget_left;
  assign prog_inc = (byte_req == magic_byte(magic_progress[1:0])) ?
                    magic_progress + 3'd1 :
                    ((byte_req == magic_byte(2'd0)) ? 3'd1 : 3'd0);
  assign hdr_ok   = (hn[0] == magic_byte(2'd0)) && (hn[1] == magic_byte(2'd1)) &&
                    (hn[2] == magic_byte(2'd2)) && (hn[3] == magic_byte(2'd3)) &&
                    (hn[4] <= max_version) && (hn[6] != 8'd0);

  always_comb begin
    status_t st;
    phase_next           = phase;
    byte_index_next      = byte_index;
    magic_progress_next  = magic_progress;
    budget_left_next     = budget_left;
    bad_frames_seen_next = bad_frames_seen;
    emit                 = 1'b0;
    st                   = ST_ERROR;
    if (accept) begin
      case (phase)
        PH_SCAN: begin
          if (prog_inc == 3'(MAGIC_BYTES)) begin
            phase_next          = PH_REST;
            byte_index_next     = IDX_W'(REST_START);
            magic_progress_next = '0;
            budget_left_next    = bl_dec;
          end else if (bl_dec == '0) begin
            phase_next          = PH_COLLECT;
            byte_index_next     = '0;
            magic_progress_next = '0;
            budget_left_next    = bl_dec;
            emit                = 1'b1;
          end else begin
            magic_progress_next = prog_inc;
            budget_left_next    = bl_dec;
          end
        end
        PH_REST: begin
          byte_index_next = byte_index + IDX_W'(1);
          if (byte_index == IDX_W'(HEADER_BYTES - 1)) begin
            phase_next          = PH_COLLECT;
            byte_index_next     = '0;
            magic_progress_next = '0;
            emit                = 1'b1;
            st                  = (hn[4] <= max_version) ? ST_RESYNC : ST_ERROR;
          end
        end
        default: begin
          phase_next      = PH_COLLECT;
          byte_index_next = byte_index + IDX_W'(1);
          if (byte_index == IDX_W'(HEADER_BYTES - 1)) begin
            byte_index_next     = '0;
            magic_progress_next = '0;
            if (hdr_ok) begin
              emit = 1'b1;
              st   = ST_OK;
            end else begin
              bad_frames_seen_next = bad_frames_seen + 32'd1;
              budget_left_next     = resync_budget;
              if (resync_budget == '0) begin
                emit = 1'b1;
              end else begin
                phase_next = PH_SCAN;
              end
            end
          end
        end
      endcase
    end

    res_new = '0;
    res_new.status          = st;
    res_new.bad_frame_total = bad_frames_seen_next;
    if (st != ST_ERROR) begin
      res_new.version       = hn[4];
      res_new.flags         = hn[5];
      res_new.msg_type      = hn[6];
      res_new.model_code    = hn[7];
      res_new.seq           = {hn[11], hn[10], hn[9], hn[8]};
      res_new.timestamp     = {hn[19], hn[18], hn[17], hn[16],
                               hn[15], hn[14], hn[13], hn[12]};
      res_new.source_length = {hn[23], hn[22], hn[21], hn[20]};
      res_new.body_length   = {hn[27], hn[26], hn[25], hn[24]};
      res_new.body_check    = {hn[31], hn[30], hn[29], hn[28]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_COLLECT;
      byte_index      <= '0;
      magic_progress  <= '0;
      budget_left     <= RESYNC_BUDGET_RST;
      bad_frames_seen <= '0;
    end else begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      magic_progress  <= magic_progress_next;
      budget_left     <= budget_left_next;
      bad_frames_seen <= bad_frames_seen_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || take) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || take) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else if (emit) begin
        out_q <= res_new;
      end
    end else if (emit) begin
      skid_q <= res_new;
    end
  end

  assign status          = out_q.status;
  assign version         = out_q.version;
  assign flags           = out_q.flags;
  assign msg_type        = out_q.msg_type;
  assign model_code      = out_q.model_code;
  assign seq             = out_q.seq;
  assign timestamp       = out_q.timestamp;
  assign source_length   = out_q.source_length;
  assign body_length     = out_q.body_length;
  assign body_check      = out_q.body_check;
  assign bad_frame_total = out_q.bad_frame_total;

endmodule

[design/hdrdf_cell.sv]
// One byte cell of the header shift line.
module hdrdf_cell import hdrdf_pkg::*; (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  output logic [7:0] dout
);

  always_ff @(posedge clk) begin
    if (shift) begin
      dout <= din;
    end
  end

endmodule

[design/hdrdf_checker.sv]
// Port-level checks for the header deframer, bound to the top level.
module hdrdf_checker import hdrdf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [1:0]  status,
  input logic [7:0]  version,
  input logic [31:0] seq,
  input logic [63:0] timestamp,
  input logic [31:0] bad_frame_total
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) &&
                               $stable(bad_frame_total))
    else $error("rsp transaction changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status == ST_OK || status == ST_RESYNC || status == ST_ERROR))
    else $error("rsp status code out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_ERROR |-> version == 8'd0 && seq == 32'd0 &&
                                         timestamp == 64'd0)
    else $error("error transaction carries header data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("block not idle after reset");

endmodule

bind header_deframer_magic_resync hdrdf_checker u_hdrdf_checker (
  .clk            (clk),
  .rst            (rst),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .status         (status),
  .version        (version),
  .seq            (seq),
  .timestamp      (timestamp),
  .bad_frame_total(bad_frame_total)
);

[bench/deframer_checker.sv]
`timescale 1ns / 100ps
// Checker for the header deframer: tracks the byte stream, predicts each header result, compares.
module deframer_checker import hdrdf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [7:0]  byte_req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [1:0]  status,
  input  logic [7:0]  version,
  input  logic [7:0]  flags,
  input  logic [7:0]  msg_type,
  input  logic [7:0]  model_code,
  input  logic [31:0] seq,
  input  logic [63:0] timestamp,
  input  logic [31:0] source_length,
  input  logic [31:0] body_length,
  input  logic [31:0] body_check,
  input  logic [31:0] bad_frame_total,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output logic        aligned
);

  localparam logic [31:0] MAGIC_WORD = "NPST";

  phase_t      ph;
  int          idx;
  int          match_cnt;
  logic [7:0]  hb [HEADER_BYTES];
  logic [23:0] budget_left;
  logic [23:0] budget_cfg;
  logic [7:0]  max_ver;
  logic [31:0] bad_count;
  hdr_res_t    headers_due [$];

  function automatic logic [7:0] magic_char(input int k);
    return MAGIC_WORD[8*(3-k) +: 8];
  endfunction

  function automatic hdr_res_t header_fields(input status_t st);
    hdr_res_t r;
    r.status          = st;
    r.version         = hb[4];
    r.flags           = hb[5];
    r.msg_type        = hb[6];
    r.model_code      = hb[7];
    r.seq             = {hb[11], hb[10], hb[9], hb[8]};
    r.timestamp       = {hb[19], hb[18], hb[17], hb[16], hb[15], hb[14], hb[13], hb[12]};
    r.source_length   = {hb[23], hb[22], hb[21], hb[20]};
    r.body_length     = {hb[27], hb[26], hb[25], hb[24]};
    r.body_check      = {hb[31], hb[30], hb[29], hb[28]};
    r.bad_frame_total = bad_count;
    return r;
  endfunction

  function automatic hdr_res_t error_fields();
    hdr_res_t r;
    r = '0;
    r.status = ST_ERROR;
    r.bad_frame_total = bad_count;
    return r;
  endfunction

  task automatic restart_collect();
    ph = PH_COLLECT;
    idx = 0;
    match_cnt = 0;
  endtask

  task automatic track_byte(input logic [7:0] b);
    case (ph)
      PH_SCAN: begin
        if (budget_left != 0) budget_left--;
        if (b == magic_char(match_cnt)) begin
          match_cnt++;
        end else begin
          match_cnt = (b == magic_char(0)) ? 1 : 0;
        end
        if (match_cnt >= MAGIC_BYTES) begin
          for (int k = 0; k < MAGIC_BYTES; k++) hb[k] = magic_char(k);
          ph = PH_REST;
          idx = REST_START;
          match_cnt = 0;
        end else if (budget_left == 0) begin
          restart_collect();
          headers_due.push_back(error_fields());
        end
      end
      PH_REST: begin
        hb[idx] = b;
        idx++;
        if (idx == HEADER_BYTES) begin
          restart_collect();
          if (hb[4] > max_ver) headers_due.push_back(error_fields());
          else headers_due.push_back(header_fields(ST_RESYNC));
        end
      end
      default: begin
        ph = PH_COLLECT;
        hb[idx] = b;
        idx++;
        if (idx == HEADER_BYTES) begin
          if ({hb[0], hb[1], hb[2], hb[3]} == MAGIC_WORD && hb[4] <= max_ver && hb[6] != 8'h00)
          begin
            restart_collect();
            headers_due.push_back(header_fields(ST_OK));
          end else begin
            bad_count++;
            budget_left = budget_cfg;
            if (budget_left == 0) begin
              restart_collect();
              headers_due.push_back(error_fields());
            end else begin
              ph = PH_SCAN;
              idx = 0;
              match_cnt = 0;
            end
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    hdr_res_t want;
    if (rst) begin
      max_ver = MAX_VERSION_RST;
      budget_cfg = RESYNC_BUDGET_RST;
      budget_left = RESYNC_BUDGET_RST;
      bad_count = '0;
      for (int k = 0; k < HEADER_BYTES; k++) hb[k] = 8'h00;
      headers_due.delete();
      restart_collect();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (headers_due.size() == 0) begin
          $display("%0t: result with no header due, expected none, got status %0d",
                   $time, status);
          mismatches++;
        end else begin
          want = headers_due.pop_front();
          check_field("status", 64'(want.status), 64'(status));
          check_field("version", 64'(want.version), 64'(version));
          check_field("flags", 64'(want.flags), 64'(flags));
          check_field("msg_type", 64'(want.msg_type), 64'(msg_type));
          check_field("model_code", 64'(want.model_code), 64'(model_code));
          check_field("seq", 64'(want.seq), 64'(seq));
          check_field("timestamp", want.timestamp, timestamp);
          check_field("source_length", 64'(want.source_length), 64'(source_length));
          check_field("body_length", 64'(want.body_length), 64'(body_length));
          check_field("body_check", 64'(want.body_check), 64'(body_check));
          check_field("bad_frame_total", 64'(want.bad_frame_total), 64'(bad_frame_total));
        end
      end
      if (req_valid && !req_stall) track_byte(byte_req);
      if (cfg_we) begin
        if (cfg_index == REG_MAX_VERSION) max_ver = cfg_data[7:0];
        else budget_cfg = cfg_data;
      end
    end
    pending = headers_due.size();
    aligned = (ph == PH_COLLECT) && (idx == 0);
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// Testbench top for the header deframer: byte stimulus, register writes and the verdict.
module testbench;
  import hdrdf_pkg::*;

  localparam int          STREAM_BYTES = 1900;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [7:0]  SYM_N        = "N";
  localparam logic [7:0]  SYM_P        = "P";
  localparam logic [7:0]  SYM_S        = "S";
  localparam logic [7:0]  SYM_T        = "T";
  localparam logic [31:0] MAGIC_WORD   = {SYM_N, SYM_P, SYM_S, SYM_T};

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [7:0]  byte_req;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [1:0]  status;
  logic [7:0]  version;
  logic [7:0]  flags;
  logic [7:0]  msg_type;
  logic [7:0]  model_code;
  logic [31:0] seq;
  logic [63:0] timestamp;
  logic [31:0] source_length;
  logic [31:0] body_length;
  logic [31:0] body_check;
  logic [31:0] bad_frame_total;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [23:0] cfg_data;

  int          mismatches;
  int          pending;
  logic        aligned;
  logic [7:0]  cur_max;
  logic [23:0] cur_budget;
  bit          quiet;
  int          bytes_sent;
  int          cycles;
  int          stall_run;

  header_deframer_magic_resync dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .byte_req(byte_req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .version(version), .flags(flags), .msg_type(msg_type),
    .model_code(model_code), .seq(seq), .timestamp(timestamp),
    .source_length(source_length),
    .body_length(body_length), .body_check(body_check),
    .bad_frame_total(bad_frame_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  deframer_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .byte_req(byte_req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .version(version), .flags(flags), .msg_type(msg_type),
    .model_code(model_code), .seq(seq), .timestamp(timestamp),
    .source_length(source_length),
    .body_length(body_length), .body_check(body_check),
    .bad_frame_total(bad_frame_total),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .aligned(aligned)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rsp_stall = 1'b0;
    stall_run = 0;
    forever begin
      @(negedge clk);
      if (stall_run > 0) begin
        rsp_stall = 1'b1;
        stall_run--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_stall = 1'b1;
        stall_run = $urandom_range(0, 3);
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 4);
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    byte_req = b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic push_magic();
    for (int k = 0; k < MAGIC_BYTES; k++) push_byte(MAGIC_WORD[8*(3-k) +: 8]);
  endtask

  // fill < 0 gives random bytes; a resynced header skips its magic
  task automatic send_header(input logic [7:0] ver, input logic [7:0] mtype,
                             input bit bad_magic, input bit resynced, input int fill);
    logic [7:0] h [HEADER_BYTES];
    int pos;
    for (int i = 0; i < HEADER_BYTES; i++) h[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    for (int k = 0; k < MAGIC_BYTES; k++) h[k] = MAGIC_WORD[8*(3-k) +: 8];
    if (bad_magic) begin
      pos = $urandom_range(0, MAGIC_BYTES - 1);
      h[pos] = h[pos] ^ 8'($urandom_range(1, 255));
    end
    h[4] = ver;
    h[6] = mtype;
    for (int i = resynced ? REST_START : 0; i < HEADER_BYTES; i++) push_byte(h[i]);
  endtask

  function automatic logic [7:0] pick_ver(input bit ok);
    if (ok) return ($urandom_range(0, 3) == 0) ? cur_max : 8'($urandom_range(0, cur_max));
    return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(int'(cur_max) + 1, 255));
  endfunction

  // bias toward magic letters but never complete the magic
  function automatic logic [7:0] scan_noise();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: b = SYM_N;
      1: b = SYM_P;
      2: b = SYM_S;
      default: b = 8'($urandom);
    endcase
    if (b == SYM_T) b = ~b;
    return b;
  endfunction

  task automatic resync();
    int g;
    if (cur_budget >= 4 && (cur_budget > 64 || $urandom_range(0, 3) != 0)) begin
      g = $urandom_range(0, (cur_budget > 16) ? 12 : int'(cur_budget) - 4);
      repeat (g) push_byte(scan_noise());
      push_magic();
      send_header(pick_ver(cur_max == 8'hFF || $urandom_range(0, 3) != 0),
                  ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                  1'b0, 1'b1, -1);
    end else begin
      repeat (cur_budget) push_byte(scan_noise());
    end
  endtask

  task automatic send_rejected();
    int why;
    why = $urandom_range(0, 2);
    if (why == 1 && cur_max == 8'hFF) why = 0;
    send_header(pick_ver(why != 1), (why == 2) ? 8'h00 : 8'($urandom_range(1, 255)),
                why == 0, 1'b0, -1);
    if (cur_budget != 0) resync();
  endtask

  // hold the stream until every header result is out, then write
  task automatic write_reg(input cfg_reg_t r, input logic [23:0] d);
    @(negedge clk);
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = r;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    if (r == REG_MAX_VERSION) cur_max = d[7:0];
    else cur_budget = d;
  endtask

  task automatic reconfigure();
    logic [7:0]  v;
    logic [23:0] bud;
    case ($urandom_range(0, 3))
      0: v = 8'h00;
      1: v = 8'h01;
      2: v = 8'hFF;
      default: v = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: bud = 24'd0;
      1: bud = 24'd1;
      2: bud = 24'($urandom_range(2, 5));
      5: bud = 24'd4096;
      6: bud = 24'hFFFFFF;
      default: bud = 24'($urandom_range(6, 64));
    endcase
    if ($urandom_range(0, 2) != 0) write_reg(REG_MAX_VERSION, {16'($urandom), v});
    if ($urandom_range(0, 2) != 0) write_reg(REG_RESYNC_BUDGET, bud);
  endtask

  // feed random bytes until the stream sits on a header boundary again
  task automatic realign();
    @(negedge clk);
    req_valid = 1'b0;
    while (!aligned) begin
      push_byte(8'($urandom));
      @(negedge clk);
      req_valid = 1'b0;
    end
  endtask

  task automatic random_frame();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 90 && cur_budget <= 64) begin
      repeat ($urandom_range(1, 40)) push_byte(8'($urandom));
      realign();
    end else if (pick >= 50) begin
      send_rejected();
    end else begin
      send_header(pick_ver(1'b1), 8'($urandom_range(1, 255)), 1'b0, 1'b0, -1);
    end
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    byte_req = 8'h00;
    cfg_we = 1'b0;
    cfg_index = REG_MAX_VERSION;
    cfg_data = 24'd0;
    quiet = 1'b0;
    bytes_sent = 0;
    cur_max = MAX_VERSION_RST;
    cur_budget = RESYNC_BUDGET_RST;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_header(8'h00, 8'h01, 1'b0, 1'b0, 8'h00);
    send_header(8'h01, 8'hFF, 1'b0, 1'b0, 8'hFF);
    send_header(8'h02, 8'h05, 1'b0, 1'b0, -1);
    push_byte(SYM_N);
    push_magic();
    send_header(8'h01, 8'h00, 1'b0, 1'b1, -1);
    send_header(8'h00, 8'h00, 1'b0, 1'b0, -1);
    push_byte(SYM_N);
    push_byte(SYM_P);
    push_byte(SYM_S);
    push_magic();
    send_header(8'h09, 8'h03, 1'b0, 1'b1, -1);
    send_header(8'h01, 8'h02, 1'b1, 1'b0, -1);
    push_byte(SYM_N);
    push_byte(SYM_P);
    push_magic();
    send_header(8'h00, 8'h07, 1'b0, 1'b1, 8'hFF);

    write_reg(REG_RESYNC_BUDGET, 24'd0);
    write_reg(REG_MAX_VERSION, 24'hFFFFFF);
    send_header(8'h10, 8'h01, 1'b1, 1'b0, -1);
    send_header(8'hFF, 8'h80, 1'b0, 1'b0, -1);

    write_reg(REG_MAX_VERSION, 24'd0);
    write_reg(REG_RESYNC_BUDGET, 24'd4);
    send_header(8'h01, 8'h01, 1'b0, 1'b0, -1);
    push_magic();
    send_header(8'h00, 8'h00, 1'b0, 1'b1, -1);
    send_header(8'h00, 8'h00, 1'b0, 1'b0, -1);
    repeat (4) push_byte(SYM_S);

    write_reg(REG_RESYNC_BUDGET, 24'hFFFFFF);
    send_header(8'h00, 8'h01, 1'b1, 1'b0, -1);
    repeat (3) push_byte(scan_noise());
    push_magic();
    send_header(8'h00, 8'h44, 1'b0, 1'b1, -1);

    write_reg(REG_RESYNC_BUDGET, 24'd1);
    send_header(8'h05, 8'h01, 1'b0, 1'b0, -1);
    push_byte(SYM_N);

    while (bytes_sent < STREAM_BYTES) begin
      if (bytes_sent > STREAM_BYTES * 85 / 100) quiet = 1'b1;
      reconfigure();
      repeat ($urandom_range(3, 10)) begin
        if (bytes_sent < STREAM_BYTES) random_frame();
      end
    end

    @(negedge clk);
    req_valid = 1'b0;
    quiet = 1'b1;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/hdrdf_pkg.sv
design/hdrdf_cell.sv
design/header_deframer_magic_resync.sv
design/hdrdf_checker.sv
bench/deframer_checker.sv
bench/testbench.sv
